### hdl/bxrs_pkg.sv
// Shared types, key tables and constants of the block XOR-reverse scrambler.
package bxrs_pkg;

    localparam int unsigned KEY_LEN = 29;
    localparam int unsigned KEY_W = 5;
    localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(KEY_LEN - 1);
    localparam logic [7:0] INVERT_MASK = 8'hff;

    localparam logic [7:0] ENC_KEY [KEY_LEN] = '{
        8'h50, 8'h6f, 8'h73, 8'h68, 8'h65, 8'h6c, 8'h2d, 8'h6b, 8'h61, 8'h20,
        8'h74, 8'h69, 8'h20, 8'h6e, 8'h61, 8'h20, 8'h68, 8'h75, 8'h69, 8'h20,
        8'h64, 8'h72, 8'h75, 8'h67, 8'h20, 8'h61, 8'h76, 8'h65, 8'h72
    };

    localparam logic [7:0] DEC_KEY [KEY_LEN] = '{
        8'h72, 8'h65, 8'h76, 8'h61, 8'h20, 8'h67, 8'h75, 8'h72, 8'h64, 8'h20,
        8'h69, 8'h75, 8'h68, 8'h20, 8'h61, 8'h6e, 8'h20, 8'h69, 8'h74, 8'h20,
        8'h61, 8'h6b, 8'h2d, 8'h6c, 8'h65, 8'h68, 8'h73, 8'h6f, 8'h50
    };

    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_ctrl_t;

    function automatic logic [7:0] key_byte(input logic dec, input logic [KEY_W-1:0] idx);
        logic [7:0] k;
        k = dec ? DEC_KEY[idx] : ENC_KEY[idx];
        return k;
    endfunction

endpackage

### hdl/bxrs_ifs.sv
// Request channel interfaces for message bytes in and result bytes out.
interface bxrs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bxrs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

### hdl/bxrs_cell.sv
// One byte cell of the bidirectional shift chain that buffers a block.
module bxrs_cell (
    input  logic                 clk,
    input  bxrs_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]           below,
    input  logic [7:0]           above,
    output logic [7:0]           q
);
    import bxrs_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift_up)
        begin
            byte_next = below;
        end
        else if (ctrl.shift_down)
        begin
            byte_next = above;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

### hdl/block_xor_reverse_scrambler.sv
// A byte that completes no block is taken in ST_IDLE; one byte per cycle while filling.
// A full non-final block: ST_REV registers its result bytes in reverse order, one byte per cycle
// while the output accepts, BLOCK_BYTES bytes in all. A final block of n bytes: BLOCK_BYTES - n
// alignment shifts of the cell chain, then n result bytes. Input waits while a block drains.
// Reset clears control, fill count, odd flag, mode and output valid; cell bytes are not reset.
module block_xor_reverse_scrambler #(
    parameter int unsigned BLOCK_BYTES = 29
) (
    input  logic       clk,
    input  logic       rst_n,
    bxrs_in_if.sink    in_chan,
    bxrs_out_if.source out_chan,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import bxrs_pkg::*;

    localparam int unsigned CW = $clog2(BLOCK_BYTES + 1);
    localparam logic [CW-1:0] BLK = CW'(BLOCK_BYTES);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [KEY_W-1:0] KPOS_INIT = KEY_W'((BLOCK_BYTES - 1) % KEY_LEN);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_REV   = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;
    localparam logic [1:0] ST_FWD   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    skip_reg, skip_next;
    logic [KEY_W-1:0] kpos_reg, kpos_next;
    logic             odd_reg, odd_next;
    logic             inv_reg, inv_next;
    logic             mode_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    cell_ctrl_t    cell_ctrl;
    logic [7:0]    cell_q [BLOCK_BYTES];
    logic          in_acc;
    logic          load_ok;
    logic          load;
    logic [7:0]    load_byte;
    logic          load_last;
    logic [CW-1:0] fill_inc;

    // Cell 0 faces the input; the top cell faces the forward drain.
    for (genvar i = 0; i < BLOCK_BYTES; i++)
    begin : g_chain
        logic [7:0] below;
        logic [7:0] above;
        if (i == 0)
        begin : g_bottom
            assign below = in_chan.data_byte;
        end
        else
        begin : g_below
            assign below = cell_q[i-1];
        end
        if (i == BLOCK_BYTES - 1)
        begin : g_top
            assign above = 8'h00;
        end
        else
        begin : g_above
            assign above = cell_q[i+1];
        end
        bxrs_cell u_cell (
            .clk   (clk),
            .ctrl  (cell_ctrl),
            .below (below),
            .above (above),
            .q     (cell_q[i])
        );
    end

    assign in_acc   = in_chan.valid && in_chan.ready;
    assign load_ok  = !out_valid_reg || out_chan.ready;
    assign fill_inc = fill_reg + ONE;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        skip_next  = skip_reg;
        kpos_next  = kpos_reg;
        odd_next   = odd_reg;
        inv_next   = inv_reg;
        cell_ctrl  = '0;
        load       = 1'b0;
        load_byte  = 8'h00;
        load_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cell_ctrl.shift_up = 1'b1;
                    if (fill_inc == BLK && !in_chan.last_byte)
                    begin
                        state_next = ST_REV;
                        cnt_next   = BLK;
                        kpos_next  = KPOS_INIT;
                        inv_next   = odd_reg;
                        odd_next   = !odd_reg;
                        fill_next  = '0;
                    end
                    else if (in_chan.last_byte)
                    begin
                        // A partial final block is aligned to the top cell first.
                        state_next = (fill_inc == BLK) ? ST_FWD : ST_ALIGN;
                        cnt_next   = fill_inc;
                        skip_next  = BLK - fill_inc;
                        inv_next   = (fill_inc != BLK);
                        odd_next   = 1'b0;
                        fill_next  = '0;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            ST_REV:
            begin
                if (load_ok)
                begin
                    load      = 1'b1;
                    load_byte = cell_q[0] ^ key_byte(mode_reg, kpos_reg)
                                ^ (inv_reg ? INVERT_MASK : 8'h00);
                    cell_ctrl.shift_down = 1'b1;
                    cnt_next  = cnt_reg - ONE;
                    kpos_next = (kpos_reg == '0) ? KEY_LAST : kpos_reg - 1'b1;
                    if (cnt_reg == ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ALIGN:
            begin
                cell_ctrl.shift_up = 1'b1;
                skip_next = skip_reg - ONE;
                if (skip_reg == ONE)
                begin
                    state_next = ST_FWD;
                end
            end
            ST_FWD:
            begin
                if (load_ok)
                begin
                    load      = 1'b1;
                    load_byte = cell_q[BLOCK_BYTES-1] ^ (inv_reg ? INVERT_MASK : 8'h00);
                    load_last = (cnt_reg == ONE);
                    cell_ctrl.shift_up = 1'b1;
                    cnt_next  = cnt_reg - ONE;
                    if (cnt_reg == ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = load_byte;
            out_last_next  = load_last;
        end
        else if (out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            skip_reg      <= '0;
            kpos_reg      <= '0;
            odd_reg       <= 1'b0;
            inv_reg       <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            skip_reg      <= skip_next;
            kpos_reg      <= kpos_next;
            odd_reg       <= odd_next;
            inv_reg       <= inv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign in_chan.ready     = (state_reg == ST_IDLE);
    assign out_chan.valid    = out_valid_reg;
    assign out_chan.out_byte = out_byte_reg;
    assign out_chan.out_last = out_last_reg;

`ifndef NO_ASSERTIONS
    a_last_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_chan.valid && in_chan.ready && in_chan.last_byte) |=> (fill_reg == '0 && !odd_reg))
        else $error("fill count or odd flag kept after final byte");

    a_drain_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REV || state_reg == ST_FWD) |-> (cnt_reg != '0))
        else $error("drain state with no bytes left");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < BLK)
        else $error("fill count reached block size");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_last) |=> (state_reg == ST_IDLE))
        else $error("final result loaded but drain not finished");
`endif

endmodule
